// File: design/hsob_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsob_pkg
// Types, register codes and helpers shared by the handle overlay blender.
// ----------------------------------------------------------------------------
package hsob_pkg;

    localparam int PIX_W             = 8;
    localparam int SPAN_W            = 7;
    localparam int RGBA_W            = 32;
    localparam int ADDR_W            = 5;
    localparam int DATA_W            = 32;
    localparam int ROOT_W            = 14;
    localparam int ROOT_STEPS        = 7;
    localparam int ACC_W             = 16;
    localparam int MAX_HALF_SIZE_DEF = 127;

    typedef enum logic [2:0] {
        REG_SHAPE_KIND    = 3'd0,
        REG_BLEND_MODE    = 3'd1,
        REG_HALF_SIZE     = 3'd2,
        REG_FILL_ENABLE   = 3'd3,
        REG_STROKE_ENABLE = 3'd4,
        REG_FILL_RGBA     = 3'd5,
        REG_STROKE_RGBA   = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        SHAPE_SQUARE  = 2'd0,
        SHAPE_DIAMOND = 2'd1,
        SHAPE_CIRCLE  = 2'd2,
        SHAPE_CROSS   = 2'd3
    } t_shape;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_FILL   = 2'd1,
        CLS_STROKE = 2'd2
    } t_class;

    typedef struct packed {
        t_shape              shape_kind;
        logic                blend_mode;
        logic [SPAN_W-1:0]   span;
        logic                fill_enable;
        logic                stroke_enable;
        logic [RGBA_W-1:0]   fill_rgba;
        logic [RGBA_W-1:0]   stroke_rgba;
        logic [2*PIX_W-1:0]  side_sq;
    } t_cfg;

    // channel 0 red, 1 green, 2 blue
    typedef struct packed {
        logic [PIX_W-1:0]        column;
        logic [PIX_W-1:0]        line;
        logic [2:0][PIX_W-1:0]   bg;
    } t_in;

    typedef struct packed {
        logic                    pass;
        logic [SPAN_W-1:0]       dx;
        logic [SPAN_W-1:0]       dy;
        logic [2:0][PIX_W-1:0]   bg;
    } t_pix;

    typedef struct packed {
        logic [ROOT_W-1:0] op;
        logic [ROOT_W-1:0] res;
    } t_root;

    typedef struct packed {
        logic                    pass;
        logic [2:0][PIX_W-1:0]   bg;
        logic [2:0][ACC_W-1:0]   acc;
    } t_mix;

    // one step of the bitwise integer square root, bit pair b
    function automatic t_root root_step(t_root r, int b);
        logic [ROOT_W-1:0] one;
        logic [ROOT_W-1:0] trial;
        t_root             o;
        one   = ROOT_W'(1) << (2 * b);
        trial = r.res + one;
        if (r.op >= trial) begin
            o.op  = r.op - trial;
            o.res = (r.res >> 1) + one;
        end else begin
            o.op  = r.op;
            o.res = r.res >> 1;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// File: design/hsob_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsob_pix_if / hsob_rgb_if
// Valid/ready channels for background pixels in and blended pixels out.
// ----------------------------------------------------------------------------
interface hsob_pix_if;
    import hsob_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] column;
    logic [PIX_W-1:0] line;
    logic [PIX_W-1:0] bg_red;
    logic [PIX_W-1:0] bg_green;
    logic [PIX_W-1:0] bg_blue;

    modport source (output valid, column, line, bg_red, bg_green, bg_blue, input ready);
    modport sink   (input valid, column, line, bg_red, bg_green, bg_blue, output ready);
endinterface

interface hsob_rgb_if;
    import hsob_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface
`default_nettype wire

// File: design/hsob_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsob_cfg
// APB register file; saturates the span and keeps the squared box side.
// ----------------------------------------------------------------------------
module hsob_cfg #(
    parameter int MAX_HALF_SIZE = hsob_pkg::MAX_HALF_SIZE_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [hsob_pkg::ADDR_W-1:0]   paddr,
    input  wire  [hsob_pkg::DATA_W-1:0]   pwdata,
    output logic [hsob_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output hsob_pkg::t_cfg                o_cfg
);
    import hsob_pkg::*;

    localparam int                SPAN_MAX = (MAX_HALF_SIZE < (2**SPAN_W - 1)) ?
                                             MAX_HALF_SIZE : (2**SPAN_W - 1);
    localparam logic [SPAN_W-1:0] SPAN_CAP = SPAN_W'(SPAN_MAX);

    t_shape              r_shape_kind;
    logic                r_blend_mode;
    logic [SPAN_W-1:0]   r_half_size;
    logic                r_fill_enable;
    logic                r_stroke_enable;
    logic [RGBA_W-1:0]   r_fill_rgba;
    logic [RGBA_W-1:0]   r_stroke_rgba;
    logic [2*PIX_W-1:0]  r_side_sq;
    logic [SPAN_W-1:0]   span;
    logic [PIX_W-1:0]    side;
    logic                wr;
    t_reg_idx            idx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite & pready;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign span   = (r_half_size > SPAN_CAP) ? SPAN_CAP : r_half_size;
    assign side   = {span, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_kind    <= SHAPE_SQUARE;
            r_blend_mode    <= 1'b0;
            r_half_size     <= SPAN_W'(3);
            r_fill_enable   <= 1'b1;
            r_stroke_enable <= 1'b0;
            r_fill_rgba     <= RGBA_W'(32'h0000_00ff);
            r_stroke_rgba   <= RGBA_W'(32'h0000_00ff);
        end else if (wr) begin
            case (idx)
                REG_SHAPE_KIND:    r_shape_kind    <= t_shape'(pwdata[1:0]);
                REG_BLEND_MODE:    r_blend_mode    <= pwdata[0];
                REG_HALF_SIZE:     r_half_size     <= pwdata[SPAN_W-1:0];
                REG_FILL_ENABLE:   r_fill_enable   <= pwdata[0];
                REG_STROKE_ENABLE: r_stroke_enable <= pwdata[0];
                REG_FILL_RGBA:     r_fill_rgba     <= pwdata[RGBA_W-1:0];
                REG_STROKE_RGBA:   r_stroke_rgba   <= pwdata[RGBA_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_side_sq <= (2*PIX_W)'(side) * (2*PIX_W)'(side);
    end

    always_comb begin
        case (idx)
            REG_SHAPE_KIND:    prdata = DATA_W'(r_shape_kind);
            REG_BLEND_MODE:    prdata = DATA_W'(r_blend_mode);
            REG_HALF_SIZE:     prdata = DATA_W'(r_half_size);
            REG_FILL_ENABLE:   prdata = DATA_W'(r_fill_enable);
            REG_STROKE_ENABLE: prdata = DATA_W'(r_stroke_enable);
            REG_FILL_RGBA:     prdata = DATA_W'(r_fill_rgba);
            REG_STROKE_RGBA:   prdata = DATA_W'(r_stroke_rgba);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.shape_kind    = r_shape_kind;
    assign o_cfg.blend_mode    = r_blend_mode;
    assign o_cfg.span          = span;
    assign o_cfg.fill_enable   = r_fill_enable;
    assign o_cfg.stroke_enable = r_stroke_enable;
    assign o_cfg.fill_rgba     = r_fill_rgba;
    assign o_cfg.stroke_rgba   = r_stroke_rgba;
    assign o_cfg.side_sq       = r_side_sq;

endmodule
`default_nettype wire

// File: design/hsob_geom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsob_geom
// Distances from the box centre, bypass decision and circle radicands.
// ----------------------------------------------------------------------------
module hsob_geom (
    input  wire               i_clk,
    input  wire               i_en,
    input  hsob_pkg::t_in     i_in,
    input  hsob_pkg::t_cfg    i_cfg,
    output hsob_pkg::t_pix    o_pix,
    output hsob_pkg::t_root   o_z,
    output hsob_pkg::t_root   o_s
);
    import hsob_pkg::*;

    t_pix                r_pix;
    t_root               r_z;
    t_root               r_s;
    t_pix                n_pix;
    t_root               n_z;
    t_root               n_s;
    logic [PIX_W-1:0]    two_c;
    logic [PIX_W-1:0]    c_ext;
    logic [PIX_W-1:0]    dxw;
    logic [PIX_W-1:0]    dyw;
    logic [PIX_W-1:0]    dy1;
    logic [2*SPAN_W-1:0] sq_z;
    logic [2*PIX_W-1:0]  sq_s;
    logic [2*PIX_W-1:0]  rad_z;
    logic [2*PIX_W-1:0]  rad_s;

    always_comb begin
        c_ext = PIX_W'(i_cfg.span);
        two_c = {i_cfg.span, 1'b0};
        dxw   = (i_in.column >= c_ext) ? i_in.column - c_ext : c_ext - i_in.column;
        dyw   = (i_in.line >= c_ext) ? i_in.line - c_ext : c_ext - i_in.line;
        dy1   = PIX_W'(dyw[SPAN_W-1:0]) + PIX_W'(1);
        sq_z  = (2*SPAN_W)'(dyw[SPAN_W-1:0]) * (2*SPAN_W)'(dyw[SPAN_W-1:0]);
        sq_s  = (2*PIX_W)'(dy1) * (2*PIX_W)'(dy1);
        rad_z = i_cfg.side_sq - {sq_z, 2'b00};
        rad_s = i_cfg.side_sq - {sq_s[2*PIX_W-3:0], 2'b00};

        n_pix.pass = (i_cfg.span == '0)
                   | (~i_cfg.fill_enable & ~i_cfg.stroke_enable)
                   | (i_in.column > two_c) | (i_in.line > two_c);
        n_pix.dx   = dxw[SPAN_W-1:0];
        n_pix.dy   = dyw[SPAN_W-1:0];
        n_pix.bg   = i_in.bg;

        // z(a) = isqrt(floor(radicand / 4))
        n_z.op  = rad_z[2*PIX_W-1:2];
        n_z.res = '0;
        n_s.op  = rad_s[2*PIX_W-1:2];
        n_s.res = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= n_pix;
            r_z   <= n_z;
            r_s   <= n_s;
        end
    end

    assign o_pix = r_pix;
    assign o_z   = r_z;
    assign o_s   = r_s;

endmodule
`default_nettype wire

// File: design/hsob_sqrt_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsob_sqrt_stage
// A few bit pairs of the two square root lanes, then a register.
// ----------------------------------------------------------------------------
module hsob_sqrt_stage #(
    parameter int FIRST_BIT = 6,
    parameter int NUM_STEPS = 4
) (
    input  wire               i_clk,
    input  wire               i_en,
    input  hsob_pkg::t_pix    i_pix,
    input  hsob_pkg::t_root   i_z,
    input  hsob_pkg::t_root   i_s,
    output hsob_pkg::t_pix    o_pix,
    output hsob_pkg::t_root   o_z,
    output hsob_pkg::t_root   o_s
);
    import hsob_pkg::*;

    t_pix  r_pix;
    t_root r_z;
    t_root r_s;
    t_root n_z;
    t_root n_s;

    always_comb begin
        n_z = i_z;
        n_s = i_s;
        for (int i = 0; i < NUM_STEPS; i++) begin
            n_z = root_step(n_z, FIRST_BIT - i);
            n_s = root_step(n_s, FIRST_BIT - i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= i_pix;
            r_z   <= n_z;
            r_s   <= n_s;
        end
    end

    assign o_pix = r_pix;
    assign o_z   = r_z;
    assign o_s   = r_s;

endmodule
`default_nettype wire

// File: design/hsob_shade.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsob_shade
// Classifies the pixel, picks its colour and forms the blend numerators.
// ----------------------------------------------------------------------------
module hsob_shade (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  hsob_pkg::t_pix               i_pix,
    input  wire  [hsob_pkg::SPAN_W-1:0]  i_z,
    input  wire  [hsob_pkg::SPAN_W-1:0]  i_s,
    input  hsob_pkg::t_cfg               i_cfg,
    output hsob_pkg::t_mix               o_mix
);
    import hsob_pkg::*;

    t_mix              r_mix;
    t_mix              n_mix;
    t_class            cls;
    logic [SPAN_W-1:0] c;
    logic [SPAN_W-1:0] c_dy;
    logic              s_neg;
    logic [RGBA_W-1:0] fill_c;
    logic [RGBA_W-1:0] strk_c;
    logic [RGBA_W-1:0] colour;
    logic [PIX_W-1:0]  alpha;
    logic [PIX_W-1:0]  cb;
    logic [PIX_W-1:0]  b;

    always_comb begin
        c     = i_cfg.span;
        c_dy  = c - i_pix.dy;
        s_neg = (i_pix.dy == c);

        case (i_cfg.shape_kind)
            SHAPE_SQUARE: begin
                cls = ((i_pix.dx == c) || (i_pix.dy == c)) ? CLS_STROKE : CLS_FILL;
            end
            SHAPE_DIAMOND: begin
                if (i_pix.dx == c_dy)     cls = CLS_STROKE;
                else if (i_pix.dx < c_dy) cls = CLS_FILL;
                else                      cls = CLS_NONE;
            end
            SHAPE_CIRCLE: begin
                if ((i_pix.dx == i_z)
                        || ((i_pix.dx <= i_z) && (s_neg || (i_pix.dx > i_s))))
                    cls = CLS_STROKE;
                else if (!s_neg && (i_pix.dx <= i_s) && (i_pix.dx < i_z))
                    cls = CLS_FILL;
                else
                    cls = CLS_NONE;
            end
            SHAPE_CROSS: begin
                cls = (i_pix.dx == i_pix.dy) ? CLS_STROKE : CLS_NONE;
            end
            default: cls = CLS_NONE;
        endcase

        fill_c = i_cfg.fill_enable ? i_cfg.fill_rgba : '0;
        strk_c = i_cfg.stroke_enable ? i_cfg.stroke_rgba : fill_c;
        colour = (cls == CLS_STROKE) ? strk_c : fill_c;
        alpha  = colour[PIX_W-1:0];

        n_mix.pass = i_pix.pass | (cls == CLS_NONE);
        n_mix.bg   = i_pix.bg;
        for (int k = 0; k < 3; k++) begin
            cb = colour[RGBA_W-1-PIX_W*k -: PIX_W];
            b  = i_cfg.blend_mode ? (i_pix.bg[k] ^ cb) : i_pix.bg[k];
            n_mix.acc[k] = ACC_W'(ACC_W'(8'd255 - alpha) * ACC_W'(b))
                         + ACC_W'(ACC_W'(cb) * ACC_W'(alpha))
                         + ACC_W'(127);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mix <= n_mix;
        end
    end

    assign o_mix = r_mix;

endmodule
`default_nettype wire

// File: design/hsob_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsob_blend
// Holds the output pixel: blend numerators divided by 255, or the background.
// ----------------------------------------------------------------------------
module hsob_blend (
    input  wire                                i_clk,
    input  wire                                i_en,
    input  hsob_pkg::t_mix                     i_mix,
    output logic [2:0][hsob_pkg::PIX_W-1:0]    o_rgb
);
    import hsob_pkg::*;

    logic [2:0][PIX_W-1:0] r_rgb;
    logic [2:0][PIX_W-1:0] n_rgb;
    logic [ACC_W:0]        q;

    // x / 255 == (x + 1 + (x >> 8)) >> 8 over the numerator range
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            q = (ACC_W+1)'(i_mix.acc[k]) + (ACC_W+1)'(1)
              + (ACC_W+1)'(i_mix.acc[k][ACC_W-1:PIX_W]);
            n_rgb[k] = i_mix.pass ? i_mix.bg[k] : q[ACC_W-1:PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;

endmodule
`default_nettype wire

// File: design/handle_sprite_overlay_blend_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// handle_sprite_overlay_blend_core
// Blends a square, diamond, circle or cross handle over background pixels.
// Takes one pixel per clock, while the output is not stalled, through six
// register stages: input register, geometry and radicands, two stages of
// the integer square root lanes for the circle edge, shading with the blend
// products, and the divide-by-255 output register. Every stage stalls only
// when it is full and the stage after it does not advance, so bubbles are
// squeezed out behind a stalled output. The user must write registers over
// APB only while no pixel is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module handle_sprite_overlay_blend_core #(
    parameter int MAX_HALF_SIZE = hsob_pkg::MAX_HALF_SIZE_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    hsob_pix_if.sink                      i_pix,
    hsob_rgb_if.source                    o_rgb,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [hsob_pkg::ADDR_W-1:0]   paddr,
    input  wire  [hsob_pkg::DATA_W-1:0]   pwdata,
    output logic [hsob_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import hsob_pkg::*;

    localparam int NSTG   = 6;
    localparam int STEPS1 = (ROOT_STEPS + 1) / 2;
    localparam int STEPS2 = ROOT_STEPS - STEPS1;

    t_cfg                  cfg;
    logic [NSTG:1]         r_v;
    logic [NSTG+1:1]       en;
    t_in                   r_s1;
    t_pix                  pix2, pix3, pix4;
    t_root                 z2, z3, z4;
    t_root                 s2, s3, s4;
    t_mix                  mix5;
    logic [2:0][PIX_W-1:0] rgb;

    hsob_cfg #(
        .MAX_HALF_SIZE (MAX_HALF_SIZE)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // stage advances when empty or when the next one advances
    always_comb begin
        en[NSTG+1] = o_rgb.ready;
        for (int k = NSTG; k >= 1; k--) begin
            en[k] = ~r_v[k] | en[k+1];
        end
    end

    assign i_pix.ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_pix.valid;
            for (int k = 2; k <= NSTG; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1.column <= i_pix.column;
            r_s1.line   <= i_pix.line;
            r_s1.bg[0]  <= i_pix.bg_red;
            r_s1.bg[1]  <= i_pix.bg_green;
            r_s1.bg[2]  <= i_pix.bg_blue;
        end
    end

    hsob_geom u_geom (
        .i_clk (i_clk),
        .i_en  (en[2]),
        .i_in  (r_s1),
        .i_cfg (cfg),
        .o_pix (pix2),
        .o_z   (z2),
        .o_s   (s2)
    );

    hsob_sqrt_stage #(
        .FIRST_BIT (ROOT_STEPS - 1),
        .NUM_STEPS (STEPS1)
    ) u_sqrt_hi (
        .i_clk (i_clk),
        .i_en  (en[3]),
        .i_pix (pix2),
        .i_z   (z2),
        .i_s   (s2),
        .o_pix (pix3),
        .o_z   (z3),
        .o_s   (s3)
    );

    hsob_sqrt_stage #(
        .FIRST_BIT (STEPS2 - 1),
        .NUM_STEPS (STEPS2)
    ) u_sqrt_lo (
        .i_clk (i_clk),
        .i_en  (en[4]),
        .i_pix (pix3),
        .i_z   (z3),
        .i_s   (s3),
        .o_pix (pix4),
        .o_z   (z4),
        .o_s   (s4)
    );

    hsob_shade u_shade (
        .i_clk (i_clk),
        .i_en  (en[5]),
        .i_pix (pix4),
        .i_z   (z4.res[SPAN_W-1:0]),
        .i_s   (s4.res[SPAN_W-1:0]),
        .i_cfg (cfg),
        .o_mix (mix5)
    );

    hsob_blend u_blend (
        .i_clk (i_clk),
        .i_en  (en[6]),
        .i_mix (mix5),
        .o_rgb (rgb)
    );

    assign o_rgb.valid     = r_v[NSTG];
    assign o_rgb.out_red   = rgb[0];
    assign o_rgb.out_green = rgb[1];
    assign o_rgb.out_blue  = rgb[2];

endmodule
`default_nettype wire

// File: sim/hsob_blend_checker.sv
// ----------------------------------------------------------------------------
// hsob_blend_checker
// Watches the pixel, result and APB ports of the handle overlay blender.
// Keeps a shadow of the registers, works out the blended RGB of every
// accepted pixel request and compares results in order, channel by channel.
// ----------------------------------------------------------------------------
module hsob_blend_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    hsob_pix_if                          i_pix,
    hsob_rgb_if                          i_rgb,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [hsob_pkg::ADDR_W-1:0]  paddr,
    input  wire  [hsob_pkg::DATA_W-1:0]  pwdata,
    input  wire                          pready,
    output int                           o_pending,
    output int                           o_mismatches
);
    import hsob_pkg::*;

    localparam int PRINT_CAP = 200;

    typedef struct packed {
        t_shape            shape;
        logic              xor_bg;
        logic [SPAN_W-1:0] span;
        logic              fill_on;
        logic              stroke_on;
        logic [RGBA_W-1:0] fill_rgba;
        logic [RGBA_W-1:0] stroke_rgba;
    } handle_regs_t;

    handle_regs_t          regs;
    logic [2:0][PIX_W-1:0] rgb_due[$];
    int                    misses = 0;

    assign o_mismatches = misses;

    task automatic flag_mismatch(input string msg);
        if (misses < PRINT_CAP) begin
            $display("%0t mismatch: %s", $time, msg);
        end
        misses++;
    endtask

    // widest half-chord z with 4z^2 <= (2c+1)^2 - 4a^2
    function automatic int circle_reach(int c, int a);
        int n;
        int z;
        n = (2 * c + 1) * (2 * c + 1) - 4 * a * a;
        z = c;
        while (z > 0 && 4 * z * z > n) z--;
        return z;
    endfunction

    function automatic t_class handle_class(int c, int dx, int dy);
        int z;
        int s;
        int lim;
        case (regs.shape)
            SHAPE_SQUARE: begin
                return (dx == c || dy == c) ? CLS_STROKE : CLS_FILL;
            end
            SHAPE_DIAMOND: begin
                if (dx == c - dy) return CLS_STROKE;
                return (dx < c - dy) ? CLS_FILL : CLS_NONE;
            end
            SHAPE_CIRCLE: begin
                z   = circle_reach(c, dy);
                s   = (dy >= c) ? -1 : circle_reach(c, dy + 1);
                lim = (s < z - 1) ? s : z - 1;
                if ((dx > s && dx <= z) || dx == z) return CLS_STROKE;
                return (dx <= lim) ? CLS_FILL : CLS_NONE;
            end
            default: begin
                return (dx == dy) ? CLS_STROKE : CLS_NONE;
            end
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] mix_channel(int hue, int alpha, int under);
        int base;
        base = regs.xor_bg ? (under ^ hue) : under;
        return PIX_W'(((255 - alpha) * base + hue * alpha + 127) / 255);
    endfunction

    function automatic logic [2:0][PIX_W-1:0] blend_pixel(t_in px);
        int                    c;
        int                    col;
        int                    row;
        int                    dx;
        int                    dy;
        t_class                cls;
        logic [RGBA_W-1:0]     fill;
        logic [RGBA_W-1:0]     strk;
        logic [RGBA_W-1:0]     paint;
        logic [2:0][PIX_W-1:0] rgb;
        rgb = px.bg;
        c   = regs.span;
        col = px.column;
        row = px.line;
        if (c == 0 || !(regs.fill_on || regs.stroke_on)) return rgb;
        if (col > 2 * c || row > 2 * c) return rgb;
        dx  = (col > c) ? col - c : c - col;
        dy  = (row > c) ? row - c : c - row;
        cls = handle_class(c, dx, dy);
        if (cls == CLS_NONE) return rgb;
        fill  = regs.fill_on ? regs.fill_rgba : '0;
        strk  = regs.stroke_on ? regs.stroke_rgba : fill;
        paint = (cls == CLS_STROKE) ? strk : fill;
        for (int k = 0; k < 3; k++) begin
            rgb[k] = mix_channel(paint[31 - 8 * k -: 8], paint[7:0], px.bg[k]);
        end
        return rgb;
    endfunction

    always @(posedge i_clk) begin
        logic [2:0][PIX_W-1:0] got;
        logic [2:0][PIX_W-1:0] want;
        t_in                   px;
        if (!i_rst_n) begin
            regs.shape       = SHAPE_SQUARE;
            regs.xor_bg      = 1'b0;
            regs.span        = SPAN_W'(3);
            regs.fill_on     = 1'b1;
            regs.stroke_on   = 1'b0;
            regs.fill_rgba   = 32'h0000_00ff;
            regs.stroke_rgba = 32'h0000_00ff;
            rgb_due.delete();
        end else begin
            if (i_rgb.valid && i_rgb.ready) begin
                got = {i_rgb.out_blue, i_rgb.out_green, i_rgb.out_red};
                if (rgb_due.size() == 0) begin
                    flag_mismatch($sformatf("result %h with no request pending", got));
                end else begin
                    want = rgb_due.pop_front();
                    if (got[0] !== want[0])
                        flag_mismatch($sformatf("red got %0d want %0d", got[0], want[0]));
                    if (got[1] !== want[1])
                        flag_mismatch($sformatf("green got %0d want %0d", got[1], want[1]));
                    if (got[2] !== want[2])
                        flag_mismatch($sformatf("blue got %0d want %0d", got[2], want[2]));
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                px.column = i_pix.column;
                px.line   = i_pix.line;
                px.bg     = {i_pix.bg_blue, i_pix.bg_green, i_pix.bg_red};
                rgb_due.push_back(blend_pixel(px));
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[ADDR_W-1:2]))
                    REG_SHAPE_KIND:    regs.shape       = t_shape'(pwdata[1:0]);
                    REG_BLEND_MODE:    regs.xor_bg      = pwdata[0];
                    REG_HALF_SIZE:     regs.span        = pwdata[SPAN_W-1:0];
                    REG_FILL_ENABLE:   regs.fill_on     = pwdata[0];
                    REG_STROKE_ENABLE: regs.stroke_on   = pwdata[0];
                    REG_FILL_RGBA:     regs.fill_rgba   = pwdata;
                    REG_STROKE_RGBA:   regs.stroke_rgba = pwdata;
                    default: begin
                    end
                endcase
            end
        end
        o_pending <= rgb_due.size();
    end

endmodule

// File: sim/tb_handle_sprite_overlay_blend_core.sv
// ----------------------------------------------------------------------------
// tb_handle_sprite_overlay_blend_core
// Drives pixel requests and APB register writes into the handle overlay
// blender: probes of every shape and corner case, then randomized settings
// with random pixels, idle gaps on the input and output back-pressure.
// Checking is done by hsob_blend_checker.
// ----------------------------------------------------------------------------
module tb_handle_sprite_overlay_blend_core;
    import hsob_pkg::*;

    localparam int PHASES       = 20;
    localparam int PHASE_ITEMS  = 48;
    localparam int SETTLE       = 8;
    localparam int SQUEEZE_LEN  = 80;
    localparam int WATCHDOG     = 2000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    hsob_pix_if pix ();
    hsob_rgb_if rgb ();

    int   pending;
    int   mismatches;
    int   box_span = 3;
    int   squeeze_asked = 0;
    int   squeeze_done = 0;
    int   quiet_cycles = 0;
    logic rx_calm = 1'b1;

    handle_sprite_overlay_blend_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_rgb   (rgb),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hsob_blend_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix),
        .i_rgb        (rgb),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mostly short, now and then long
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [RGBA_W-1:0] random_colour();
        logic [RGBA_W-1:0] word;
        word = $urandom;
        case ($urandom_range(0, 3))
            0: word[7:0] = 8'h00;
            1: word[7:0] = 8'hff;
            default: begin
            end
        endcase
        return word;
    endfunction

    function automatic logic [SPAN_W-1:0] random_span();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return SPAN_W'(127);
        if (r == 2) return SPAN_W'(1);
        if (r < 5) return SPAN_W'($urandom_range(40, 126));
        return SPAN_W'($urandom_range(1, 12));
    endfunction

    function automatic logic [PIX_W-1:0] random_byte();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
        return PIX_W'($urandom);
    endfunction

    function automatic t_in random_pixel();
        t_in px;
        int  lim;
        lim = (2 * box_span + 2 > 255) ? 255 : 2 * box_span + 2;
        if ($urandom_range(0, 9) < 8) begin
            px.column = PIX_W'($urandom_range(0, lim));
            px.line   = PIX_W'($urandom_range(0, lim));
        end else begin
            px.column = PIX_W'($urandom_range(0, 255));
            px.line   = PIX_W'($urandom_range(0, 255));
        end
        for (int k = 0; k < 3; k++) px.bg[k] = random_byte();
        return px;
    endfunction

    task automatic apb_write(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_handle(input t_shape shape, input logic xor_bg,
                                input logic [SPAN_W-1:0] span, input logic fill_on,
                                input logic stroke_on, input logic [RGBA_W-1:0] fill,
                                input logic [RGBA_W-1:0] stroke);
        apb_write(REG_SHAPE_KIND, DATA_W'(shape));
        apb_write(REG_BLEND_MODE, DATA_W'(xor_bg));
        apb_write(REG_HALF_SIZE, DATA_W'(span));
        apb_write(REG_FILL_ENABLE, DATA_W'(fill_on));
        apb_write(REG_STROKE_ENABLE, DATA_W'(stroke_on));
        apb_write(REG_FILL_RGBA, fill);
        apb_write(REG_STROKE_RGBA, stroke);
        box_span = int'(span);
    endtask

    task automatic send_pixel(input t_in px, input int gap);
        pix.valid    <= 1'b1;
        pix.column   <= px.column;
        pix.line     <= px.line;
        pix.bg_red   <= px.bg[0];
        pix.bg_green <= px.bg[1];
        pix.bg_blue  <= px.bg[2];
        do @(posedge i_clk); while (!pix.ready);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // centre, corner, right edge, just past the edge, far corner
    task automatic probe_box();
        t_in px;
        int  c;
        c = box_span;
        for (int n = 0; n < 5; n++) begin
            case (n)
                0: begin px.column = PIX_W'(c);     px.line = PIX_W'(c); end
                1: begin px.column = '0;            px.line = '0;        end
                2: begin px.column = PIX_W'(2 * c); px.line = PIX_W'(c); end
                3: begin
                    px.column = PIX_W'((2 * c + 1 > 255) ? 255 : 2 * c + 1);
                    px.line   = PIX_W'(c);
                end
                default: begin px.column = 8'hff;   px.line = 8'hff;     end
            endcase
            for (int k = 0; k < 3; k++) begin
                px.bg[k] = (n == 1) ? 8'h00 : (n == 4) ? 8'hff : PIX_W'($urandom);
            end
            send_pixel(px, n % 2);
        end
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic tx_calm;
        pix.valid    = 1'b0;
        pix.column   = '0;
        pix.line     = '0;
        pix.bg_red   = '0;
        pix.bg_green = '0;
        pix.bg_blue  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_rst_n      = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        probe_box();
        drain();
        write_handle(SHAPE_CIRCLE, 1'b1, 7'd5, 1'b1, 1'b1, 32'h8040_2011, 32'hffff_ffff);
        probe_box();
        drain();
        write_handle(SHAPE_DIAMOND, 1'b0, 7'd127, 1'b1, 1'b0, 32'h1234_5600, 32'h0000_0000);
        probe_box();
        drain();
        write_handle(SHAPE_CROSS, 1'b1, 7'd1, 1'b0, 1'b1, 32'hdead_beef, 32'h00ff_00ff);
        probe_box();
        drain();
        write_handle(SHAPE_SQUARE, 1'b0, 7'd0, 1'b1, 1'b1, 32'hffff_ffff, 32'h0000_00ff);
        probe_box();
        drain();
        write_handle(SHAPE_SQUARE, 1'b1, 7'd4, 1'b0, 1'b0, 32'hffff_ffff, 32'hffff_ffff);
        probe_box();
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_handle(t_shape'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         random_span(), $urandom_range(0, 4) != 0,
                         1'($urandom_range(0, 1)), random_colour(), random_colour());
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (ph % 4 == 1) begin
                // output held off while input keeps coming
                tx_calm = 1'b1;
                rx_calm = 1'b1;
                squeeze_asked++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_pixel(random_pixel(), tx_calm ? 0 : idle_cycles());
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : result_side
        int run;
        int hold;
        rgb.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (squeeze_asked != squeeze_done) begin
                squeeze_done++;
                rgb.ready <= 1'b0;
                repeat (SQUEEZE_LEN) @(posedge i_clk);
            end else if (rx_calm) begin
                rgb.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                run  = $urandom_range(1, 8);
                hold = idle_cycles();
                rgb.ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                if (hold > 0) begin
                    rgb.ready <= 1'b0;
                    repeat (hold) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix.valid && pix.ready) || (rgb.valid && rgb.ready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// File: files.f
design/hsob_pkg.sv
design/hsob_if.sv
design/hsob_cfg.sv
design/hsob_geom.sv
design/hsob_sqrt_stage.sv
design/hsob_shade.sv
design/hsob_blend.sv
design/handle_sprite_overlay_blend_core.sv
sim/hsob_blend_checker.sv
sim/tb_handle_sprite_overlay_blend_core.sv
